@@ rtl/bdpq_pkg.sv @@
package bdpq_pkg;

	// Fixed geometry of the button side.
	localparam int BUTTON_COUNT = 3;
	localparam int BTN_W        = 2;
	localparam int TIME_W       = 32;
	localparam int DEB_W        = 8;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd30;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;  // latch the levels and time of a sample request
		logic             scan;  // evaluate one button
		logic             last;  // final button of the scan, commit previous levels
		logic             pop;   // remove the queue head into the result register
		logic [BTN_W-1:0] btn;   // button under evaluation
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // the result register can take a new result this cycle
	} stat_t;

endpackage

@@ rtl/bdpq_item_if.sv @@
interface bdpq_item_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [2:0]                    button_levels;
	logic [bdpq_pkg::TIME_W-1:0]   time_now;

	modport source (output valid, output operation, output button_levels, output time_now,
		input ready);
	modport sink (input valid, input operation, input button_levels, input time_now,
		output ready);
endinterface

@@ rtl/bdpq_result_if.sv @@
interface bdpq_result_if;
	logic       valid;
	logic       ready;
	logic       press_found;
	logic [1:0] button_index;

	modport source (output valid, output press_found, output button_index, input ready);
	modport sink (input valid, input press_found, input button_index, output ready);
endinterface

@@ rtl/bdpq_ctrl.sv @@
module bdpq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  bdpq_pkg::op_t         item_op,
	input  bdpq_pkg::stat_t       stat,
	output logic                  item_ready,
	output bdpq_pkg::cmd_t        cmd
);

	bdpq_pkg::state_t               state_q, state_d;
	logic [bdpq_pkg::BTN_W-1:0]     btn_q, btn_d;
	logic                           last_btn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdpq_pkg::ST_IDLE;
			btn_q   <= '0;
		end else begin
			state_q <= state_d;
			btn_q   <= btn_d;
		end
	end

	assign last_btn = (btn_q == bdpq_pkg::BTN_W'(bdpq_pkg::BUTTON_COUNT - 1));

	always_comb begin
		state_d    = state_q;
		btn_d      = btn_q;
		item_ready = 1'b0;
		cmd        = '0;
		cmd.btn    = btn_q;
		unique case (state_q)
			bdpq_pkg::ST_IDLE: begin
				item_ready = stat.out_free;
				if (item_valid && stat.out_free) begin
					if (item_op == bdpq_pkg::OP_POP) begin
						cmd.pop = 1'b1;
					end else begin
						cmd.load = 1'b1;
						btn_d    = '0;
						state_d  = bdpq_pkg::ST_SCAN;
					end
				end
			end
			bdpq_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				cmd.last = last_btn;
				if (last_btn) begin
					state_d = bdpq_pkg::ST_IDLE;
				end else begin
					btn_d = btn_q + bdpq_pkg::BTN_W'(1);
				end
			end
			default: begin
				state_d = bdpq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/bdpq_dpath.sv @@
module bdpq_dpath #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdpq_pkg::cmd_t                    cmd,
	input  logic [bdpq_pkg::BUTTON_COUNT-1:0] levels,
	input  logic [bdpq_pkg::TIME_W-1:0]       time_now,
	input  logic                              cfg_we,
	input  logic [bdpq_pkg::DEB_W-1:0]        cfg_data,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic                              res_found,
	output logic [bdpq_pkg::BTN_W-1:0]        res_index,
	output bdpq_pkg::stat_t                   stat
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QI_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [bdpq_pkg::DEB_W-1:0]        deb_q;
	logic [bdpq_pkg::BUTTON_COUNT-1:0] prev_q;
	logic [bdpq_pkg::BUTTON_COUNT-1:0] lvl_q;
	logic [bdpq_pkg::TIME_W-1:0]       time_q;
	logic [bdpq_pkg::TIME_W-1:0]       let_q [bdpq_pkg::BUTTON_COUNT];
	logic [bdpq_pkg::BTN_W-1:0]        queue_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]                  count_q;
	logic                              res_valid_q;
	logic                              res_found_q;
	logic [bdpq_pkg::BTN_W-1:0]        res_index_q;

	logic                              is_high;
	logic                              was_high;
	logic                              rise;
	logic                              edge_seen;
	logic [bdpq_pkg::TIME_W-1:0]       ready_time;
	logic                              settled;
	logic                              has_room;
	logic                              push;
	logic                              not_empty;

	// One button per scan cycle: an add of the debounce time and a compare.
	always_comb begin
		is_high    = lvl_q[cmd.btn];
		was_high   = prev_q[cmd.btn];
		rise       = is_high && !was_high;
		edge_seen  = is_high != was_high;
		ready_time = let_q[cmd.btn] + bdpq_pkg::TIME_W'(deb_q);
		settled    = time_q >= ready_time;
		has_room   = count_q < CNT_W'(QUEUE_DEPTH);
		push       = cmd.scan && rise && has_room && settled;
		not_empty  = count_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q       <= bdpq_pkg::DEBOUNCE_RESET;
			prev_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			for (int b = 0; b < bdpq_pkg::BUTTON_COUNT; b++) begin
				let_q[b] <= '0;
			end
		end else begin
			if (cfg_we) begin
				deb_q <= cfg_data;
			end
			if (cmd.scan && edge_seen) begin
				let_q[cmd.btn] <= time_q;
			end
			if (cmd.last) begin
				prev_q <= lvl_q;
			end
			if (push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop && not_empty) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: sample latch, press queue and result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lvl_q  <= levels;
			time_q <= time_now;
		end
		if (push) begin
			queue_q[count_q[QI_W-1:0]] <= cmd.btn;
		end else if (cmd.pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				queue_q[i] <= queue_q[i + 1];
			end
		end
		if (cmd.pop) begin
			res_found_q <= not_empty;
			res_index_q <= not_empty ? queue_q[0] : '0;
		end
	end

	assign res_valid    = res_valid_q;
	assign res_found    = res_found_q;
	assign res_index    = res_index_q;
	assign stat.out_free = !res_valid_q || res_ready;

endmodule

@@ rtl/button_debounce_press_queue.sv @@
// Button debounce and press queue.
//
// The item channel carries two kinds of request. A sample request
// (operation 0) brings the levels of three buttons and the current time; each
// button that rose from 0 to 1 is queued when the queue has room and the time
// has reached the button's last event time plus the hold-off time (a 32-bit
// wrapping sum). Any rise or fall records the time for that button. A pop
// request (operation 1) removes the queue head and returns it on the result
// channel, with press_found low and button_index zero when the queue is empty.
// Sample requests produce no result.
//
// A pop request yields its result in the cycle after it is accepted. A sample
// request is latched when accepted, then one adder and comparator evaluate
// the buttons in turn, and no request is taken until the scan ends. Pops can
// be taken every cycle while no result is stalled. While the receiver stalls
// a result, item.ready stays low unless that result is read in the same cycle.
// Reset clears the queue count, previous levels, event times and the pending
// result and sets the hold-off time to 30; it is to be written through cfg_we
// and cfg_data only while the block is idle, a rule left to the user to keep.
module button_debounce_press_queue #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bdpq_item_if.sink                     item,
	bdpq_result_if.source                 result,
	input  logic                          cfg_we,
	input  logic [bdpq_pkg::DEB_W-1:0]    cfg_data
);

	bdpq_pkg::cmd_t  cmd;
	bdpq_pkg::stat_t stat;
	bdpq_pkg::op_t   item_op;

	// The operation bit maps straight onto the opcode enum.
	assign item_op = bdpq_pkg::op_t'(item.operation);

	// The controller sequences requests: pops are served at once, samples
	// step through the buttons one per cycle.
	bdpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item_op),
		.stat       (stat),
		.item_ready (item.ready),
		.cmd        (cmd)
	);

	// The datapath holds the debounce register, event times, previous levels,
	// the shift queue of presses and the result register.
	bdpq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.levels    (item.button_levels[bdpq_pkg::BUTTON_COUNT-1:0]),
		.time_now  (item.time_now),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.res_ready (result.ready),
		.res_valid (result.valid),
		.res_found (result.press_found),
		.res_index (result.button_index),
		.stat      (stat)
	);

endmodule
